@@ design/wcrp_pkg.sv @@
// Shared types, register indexes, edge tables and the sine table builder
// for the wireframe cube rotate/project core. No dependencies.
package wcrp_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SCALE_PIXELS = 2'd0;
   localparam logic [1:0] CSR_CENTRE_X     = 2'd1;
   localparam logic [1:0] CSR_CENTRE_Y     = 2'd2;

   localparam logic [2:0] CORNER_LAST = 3'd7;
   localparam logic [3:0] NUM_EDGES   = 4'd12;
   localparam logic [3:0] LAST_EDGE   = 4'd11;

   // Pi in Q30 for the elaboration-time sine series.
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_LOOKUP,
      ST_CORNERS,
      ST_DRAIN,
      ST_EMIT
   } wcrp_state_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] idx;
   } corner_issue_type;

   typedef struct packed {
      logic       we;
      logic [2:0] addr;
      logic       last;
   } corner_wr_type;

   typedef struct packed {
      logic       neg;
      logic [6:0] idx;
   } fold_type;

   typedef logic [16:0] qsine_tab_type [0:90];

   // Quarter-wave sine table, entry d = round(sin(d deg) * 2^frac_bits),
   // evaluated with an integer Taylor series in Q30.
   function automatic qsine_tab_type build_quarter_sine(input int unsigned frac_bits);
      qsine_tab_type    tab;
      longint unsigned  x;
      longint unsigned  x2;
      longint unsigned  term;
      longint unsigned  sum;
      for (int d = 0; d <= 90; d++) begin
         x    = (longint'(d) * PI_Q30 + 64'd90) / 64'd180;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int k = 1; k <= 8; k++) begin
            term = (term * x2) >> 30;
            case (k)
               1:       term = term / 64'd6;
               2:       term = term / 64'd20;
               3:       term = term / 64'd42;
               4:       term = term / 64'd72;
               5:       term = term / 64'd110;
               6:       term = term / 64'd156;
               7:       term = term / 64'd210;
               default: term = term / 64'd272;
            endcase
            if ((k % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         sum = (sum + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
         tab[d] = sum[16:0];
      end
      return tab;
   endfunction

   // Edge order: bottom face, top face, then the four verticals.
   function automatic logic [2:0] edge_start(input logic [3:0] e);
      logic [2:0] c;
      if (e < 4'd8) begin
         c = e[2:0];
      end else begin
         c = {1'b0, e[1:0]};
      end
      return c;
   endfunction

   function automatic logic [2:0] edge_end(input logic [3:0] e);
      logic [2:0] c;
      if (e < 4'd4) begin
         c = {1'b0, e[1:0] + 2'd1};
      end else if (e < 4'd8) begin
         c = {1'b1, e[1:0] + 2'd1};
      end else begin
         c = {1'b1, e[1:0]};
      end
      return c;
   endfunction

endpackage

@@ design/wcrp_trig.sv @@
// Sine and cosine lookup for the three rotation angles, two register stages.
// Depends on wcrp_pkg for the quarter-wave table builder and fold type.
module wcrp_trig
   import wcrp_pkg::*;
#(
   parameter int TRIG_FRACTION_BITS = 14
) (
   input  logic                                clock,
   input  logic [8:0]                          angle_x,
   input  logic [8:0]                          angle_y,
   input  logic [8:0]                          angle_z,
   output logic signed [TRIG_FRACTION_BITS+1:0] sin_x,
   output logic signed [TRIG_FRACTION_BITS+1:0] cos_x,
   output logic signed [TRIG_FRACTION_BITS+1:0] sin_y,
   output logic signed [TRIG_FRACTION_BITS+1:0] cos_y,
   output logic signed [TRIG_FRACTION_BITS+1:0] sin_z,
   output logic signed [TRIG_FRACTION_BITS+1:0] cos_z
);

   localparam int TW = TRIG_FRACTION_BITS + 2;
   localparam qsine_tab_type QSINE = build_quarter_sine(TRIG_FRACTION_BITS);

   fold_type               fold_in [0:5];
   fold_type               fold_ff [0:5];
   logic signed [TW-1:0]   trig_in [0:5];
   logic signed [TW-1:0]   trig_ff [0:5];

   function automatic logic [8:0] mod360(input logic [9:0] a);
      logic [9:0] r;
      r = (a >= 10'd360) ? a - 10'd360 : a;
      return r[8:0];
   endfunction

   // Map 0..359 onto a quarter-wave index and a sign.
   function automatic fold_type fold(input logic [8:0] a);
      fold_type   f;
      logic [8:0] t;
      if (a <= 9'd90) begin
         t = a;
         f.neg = 1'b0;
      end else if (a <= 9'd180) begin
         t = 9'd180 - a;
         f.neg = 1'b0;
      end else if (a <= 9'd270) begin
         t = a - 9'd180;
         f.neg = 1'b1;
      end else begin
         t = 9'd360 - a;
         f.neg = 1'b1;
      end
      f.idx = t[6:0];
      return f;
   endfunction

   function automatic fold_type fold_pair(input logic [8:0] angle, input logic is_cos);
      logic [8:0] a;
      a = mod360({1'b0, angle});
      if (is_cos) begin
         a = mod360({1'b0, a} + 10'd90);
      end
      return fold(a);
   endfunction

   always_comb begin
      fold_in[0] = fold_pair(angle_x, 1'b0);
      fold_in[1] = fold_pair(angle_x, 1'b1);
      fold_in[2] = fold_pair(angle_y, 1'b0);
      fold_in[3] = fold_pair(angle_y, 1'b1);
      fold_in[4] = fold_pair(angle_z, 1'b0);
      fold_in[5] = fold_pair(angle_z, 1'b1);
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         trig_in[i] = signed'(TW'(QSINE[fold_ff[i].idx][TRIG_FRACTION_BITS:0]));
         if (fold_ff[i].neg) begin
            trig_in[i] = -trig_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) begin
         fold_ff[i] <= fold_in[i];
         trig_ff[i] <= trig_in[i];
      end
   end

   assign sin_x = trig_ff[0];
   assign cos_x = trig_ff[1];
   assign sin_y = trig_ff[2];
   assign cos_y = trig_ff[3];
   assign sin_z = trig_ff[4];
   assign cos_z = trig_ff[5];

endmodule

@@ design/wcrp_xform.sv @@
// Corner transform pipeline: rotate about X, Y, Z, then scale, offset and
// saturate to screen coordinates. One corner enters per cycle. Uses wcrp_pkg.
module wcrp_xform
   import wcrp_pkg::*;
#(
   parameter int TRIG_FRACTION_BITS = 14,
   parameter int SCREEN_COORD_BITS  = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  corner_issue_type                     issue,
   input  logic signed [TRIG_FRACTION_BITS+1:0] sin_x,
   input  logic signed [TRIG_FRACTION_BITS+1:0] cos_x,
   input  logic signed [TRIG_FRACTION_BITS+1:0] sin_y,
   input  logic signed [TRIG_FRACTION_BITS+1:0] cos_y,
   input  logic signed [TRIG_FRACTION_BITS+1:0] sin_z,
   input  logic signed [TRIG_FRACTION_BITS+1:0] cos_z,
   input  logic [7:0]                           scale_pixels,
   input  logic signed [10:0]                   centre_x,
   input  logic signed [10:0]                   centre_y,
   output corner_wr_type                        wr,
   output logic [2*SCREEN_COORD_BITS-1:0]       wr_data
);

   localparam int F  = TRIG_FRACTION_BITS;
   localparam int S  = SCREEN_COORD_BITS;
   localparam int CW = F + 2;          // rotated coordinate
   localparam int TW = F + 2;          // sine or cosine
   localparam int PW = CW + TW;        // coordinate times trig
   localparam int SW = PW + 1;         // sum of two products
   localparam int QW = CW + 9;         // coordinate times scale
   localparam int GW = CW + 10;        // screen sum before saturation
   localparam logic [SW-1:0]        ROUND_HALF = SW'(1) << (F - 1);
   localparam logic signed [GW-1:0] SAT_HI = GW'((1 << (S - 1)) - 1);
   localparam logic signed [GW-1:0] SAT_LO = GW'(-(1 << (S - 1)));

   // Valid and corner index travel alongside the data.
   logic [6:0]            vld_ff;
   logic [2:0]            idx_ff [0:6];
   logic [1:0]            xpos_ff;

   logic signed [CW-1:0]  s1_y_ff, s1_z_ff;
   logic signed [PW-1:0]  s2_zs_ff;
   logic signed [CW-1:0]  s2_y_ff;
   logic signed [CW-1:0]  s3_x_ff, s3_y_ff;
   logic signed [PW-1:0]  s4_p_ff [0:3];
   logic signed [CW-1:0]  s5_x_ff, s5_y_ff;
   logic signed [QW-1:0]  s6_px_ff, s6_py_ff;
   logic signed [GW-1:0]  s7_sx_ff, s7_sy_ff;

   logic signed [SW-1:0]  a_y_sum, a_z_sum, c_x_sum, e_x_sum, e_y_sum;
   logic signed [QW-1:0]  scale_s;
   logic signed [GW-1:0]  g_off_x, g_off_y;
   logic [S-1:0]          sat_x, sat_y;

   // Product of a trig value and a corner coordinate of plus or minus one half.
   function automatic logic signed [SW-1:0] half_mul(input logic pos,
                                                     input logic signed [TW-1:0] t);
      logic signed [SW-1:0] v;
      v = SW'(t) <<< (F - 1);
      return pos ? v : -v;
   endfunction

   // Round to nearest back to Q1.F, ties away from zero.
   function automatic logic signed [CW-1:0] round_back(input logic signed [SW-1:0] v);
      logic [SW-1:0] mag;
      logic [SW-1:0] r;
      mag = v[SW-1] ? SW'(-v) : SW'(v);
      r   = (mag + ROUND_HALF) >> F;
      if (v[SW-1]) begin
         r = -r;
      end
      return signed'(r[CW-1:0]);
   endfunction

   // Truncate toward zero after the scale multiply.
   function automatic logic signed [GW-1:0] trunc_off(input logic signed [QW-1:0] p);
      logic [QW-1:0] mag;
      logic [QW-1:0] o;
      mag = p[QW-1] ? QW'(-p) : QW'(p);
      o   = mag >> F;
      if (p[QW-1]) begin
         o = -o;
      end
      return GW'(signed'(o));
   endfunction

   function automatic logic [S-1:0] saturate(input logic signed [GW-1:0] v);
      logic signed [GW-1:0] c;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end else begin
         c = v;
      end
      return c[S-1:0];
   endfunction

   // Corner signs: x is positive for corners 1 and 2 of each face.
   always_comb begin
      a_y_sum = half_mul(issue.idx[1], cos_x) - half_mul(issue.idx[2], sin_x);
      a_z_sum = half_mul(issue.idx[1], sin_x) + half_mul(issue.idx[2], cos_x);
      c_x_sum = half_mul(xpos_ff[1], cos_y) + SW'(s2_zs_ff);
      e_x_sum = SW'(s4_p_ff[0]) - SW'(s4_p_ff[1]);
      e_y_sum = SW'(s4_p_ff[2]) + SW'(s4_p_ff[3]);
      scale_s = QW'(signed'({1'b0, scale_pixels}));
      g_off_x = trunc_off(s6_px_ff) + GW'(centre_x);
      g_off_y = trunc_off(s6_py_ff) + GW'(centre_y);
      sat_x   = saturate(s7_sx_ff);
      sat_y   = saturate(s7_sy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[5:0], issue.valid};
      end
   end

   always_ff @(posedge clock) begin
      idx_ff[0]  <= issue.idx;
      xpos_ff[0] <= issue.idx[0] ^ issue.idx[1];
      xpos_ff[1] <= xpos_ff[0];
      for (int i = 1; i < 7; i++) begin
         idx_ff[i]  <= idx_ff[i-1];
      end
      // Rotation about X (corner values are plus or minus one half).
      s1_y_ff <= round_back(a_y_sum);
      s1_z_ff <= round_back(a_z_sum);
      // Rotation about Y; the new z is not needed afterwards.
      s2_zs_ff <= PW'(s1_z_ff) * PW'(sin_y);
      s2_y_ff  <= s1_y_ff;
      s3_x_ff  <= round_back(c_x_sum);
      s3_y_ff  <= s2_y_ff;
      // Rotation about Z.
      s4_p_ff[0] <= PW'(s3_x_ff) * PW'(cos_z);
      s4_p_ff[1] <= PW'(s3_y_ff) * PW'(sin_z);
      s4_p_ff[2] <= PW'(s3_x_ff) * PW'(sin_z);
      s4_p_ff[3] <= PW'(s3_y_ff) * PW'(cos_z);
      s5_x_ff    <= round_back(e_x_sum);
      s5_y_ff    <= round_back(e_y_sum);
      // Projection.
      s6_px_ff   <= QW'(s5_x_ff) * scale_s;
      s6_py_ff   <= QW'(s5_y_ff) * scale_s;
      s7_sx_ff   <= g_off_x;
      s7_sy_ff   <= g_off_y;
   end

   assign wr.we   = vld_ff[6];
   assign wr.addr = idx_ff[6];
   assign wr.last = vld_ff[6] && (idx_ff[6] == CORNER_LAST);
   assign wr_data = {sat_y, sat_x};

endmodule

@@ design/wcrp_corner_ram.sv @@
// Projected corner store: eight entries, one write port and two registered
// read ports sharing one read enable. Depends on wcrp_pkg for the write type.
module wcrp_corner_ram
   import wcrp_pkg::*;
#(
   parameter int DATA_BITS = 24
) (
   input  logic                 clock,
   input  corner_wr_type        wr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [2:0]           rd_addr_a,
   input  logic [2:0]           rd_addr_b,
   output logic [DATA_BITS-1:0] rd_data_a,
   output logic [DATA_BITS-1:0] rd_data_b
);

   logic [DATA_BITS-1:0] mem_ff [0:7];
   logic [DATA_BITS-1:0] rd_a_ff;
   logic [DATA_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_ff[wr.addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ design/wireframe_cube_rotate_project_core.sv @@
// Wireframe cube rotate and project core: top level with sequencer, config
// registers and output register. Uses wcrp_pkg, wcrp_trig, wcrp_xform and
// wcrp_corner_ram.
//
// Each request transaction carries three rotation angles in whole degrees
// (values 360..511 wrap modulo 360). The core rotates the eight corners of a
// unit cube about X, then Y, then Z in Q1.F fixed point, projects them
// orthographically with the programmed scale and centre, saturates them to
// SCREEN_COORD_BITS and stores them in an eight-entry corner memory. It then
// reads that memory at both ends of each edge and sends twelve response
// transactions, one per edge, in the order bottom face, top face, verticals,
// with rsp_tlast set on the twelfth. A request is taken only when the
// previous run has handed its last edge to the output register. A run
// folds the angles, looks up the sines and cosines, issues the eight
// corners into the seven-stage transform pipeline, lets it drain into the
// corner memory, and then reads one edge per cycle through the memory's
// registered read port while the response side does not stall. The
// configuration registers (scale_pixels, centre_x, centre_y) may only be
// written while the core is idle; a write to an unused index is ignored.
module wireframe_cube_rotate_project_core
   import wcrp_pkg::*;
#(
   parameter int TRIG_FRACTION_BITS = 14,
   parameter int SCREEN_COORD_BITS  = 12
) (
   input  logic        clock,
   input  logic        reset,
   // Request: [8:0] turn_x_deg, [17:9] turn_y_deg, [26:18] turn_z_deg.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // Response: edge_number, start_x, start_y, end_x, end_y from the lowest
   // bit up, zero-padded to whole bytes.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [((4+4*SCREEN_COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic        rsp_tlast,
   // Configuration write port.
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [10:0] csr_wdata
);

   localparam int S  = SCREEN_COORD_BITS;
   localparam int TW = TRIG_FRACTION_BITS + 2;
   localparam int DW = ((4 + 4 * S + 7) / 8) * 8;

   wcrp_state_type state_ff, state_in;

   logic [7:0]          scale_ff;
   logic signed [10:0]  centre_x_ff, centre_y_ff;
   logic [8:0]          angle_x_ff, angle_y_ff, angle_z_ff;

   logic [2:0]          corner_cnt_ff, corner_cnt_in;
   logic [3:0]          edge_cnt_ff, edge_cnt_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [3:0]          rd_edge_ff, rd_edge_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          rsp_edge_ff;
   logic [S-1:0]        rsp_sx_ff, rsp_sy_ff, rsp_ex_ff, rsp_ey_ff;

   logic                req_accept;
   logic                out_load;
   logic                rd_issue;
   corner_issue_type    issue;
   corner_wr_type       wr;
   logic [2*S-1:0]      wr_data;
   logic [2*S-1:0]      rd_data_a, rd_data_b;

   logic signed [TW-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= 8'd32;
         centre_x_ff <= 11'sd64;
         centre_y_ff <= 11'sd32;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SCALE_PIXELS: scale_ff    <= csr_wdata[7:0];
            CSR_CENTRE_X:     centre_x_ff <= signed'(csr_wdata);
            CSR_CENTRE_Y:     centre_y_ff <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   // The angles are held for the whole run; the trig stages read them.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         angle_x_ff <= req_tdata[8:0];
         angle_y_ff <= req_tdata[17:9];
         angle_z_ff <= req_tdata[26:18];
      end
   end

   wcrp_trig #(
      .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
   ) u_trig (
      .clock  (clock),
      .angle_x(angle_x_ff),
      .angle_y(angle_y_ff),
      .angle_z(angle_z_ff),
      .sin_x  (sin_x),
      .cos_x  (cos_x),
      .sin_y  (sin_y),
      .cos_y  (cos_y),
      .sin_z  (sin_z),
      .cos_z  (cos_z)
   );

   wcrp_xform #(
      .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS),
      .SCREEN_COORD_BITS (SCREEN_COORD_BITS)
   ) u_xform (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .sin_x       (sin_x),
      .cos_x       (cos_x),
      .sin_y       (sin_y),
      .cos_y       (cos_y),
      .sin_z       (sin_z),
      .cos_z       (cos_z),
      .scale_pixels(scale_ff),
      .centre_x    (centre_x_ff),
      .centre_y    (centre_y_ff),
      .wr          (wr),
      .wr_data     (wr_data)
   );

   wcrp_corner_ram #(
      .DATA_BITS(2 * S)
   ) u_ram (
      .clock    (clock),
      .wr       (wr),
      .wr_data  (wr_data),
      .rd_en    (rd_issue),
      .rd_addr_a(edge_start(edge_cnt_ff)),
      .rd_addr_b(edge_end(edge_cnt_ff)),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   // The memory read register and the output register form a two-entry
   // pipe: while edges remain to be emitted, a new read is issued whenever
   // the read register is empty or moves into the output register in the same cycle.
   assign out_load   = rd_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign rd_issue   = (state_ff == ST_EMIT) && (edge_cnt_ff != NUM_EDGES) &&
                       (!rd_valid_ff || out_load);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      corner_cnt_in = corner_cnt_ff;
      edge_cnt_in   = edge_cnt_ff;
      req_tready    = 1'b0;
      issue.valid   = 1'b0;
      issue.idx     = corner_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            corner_cnt_in = '0;
            state_in      = ST_CORNERS;
         end
         ST_CORNERS: begin
            issue.valid   = 1'b1;
            corner_cnt_in = corner_cnt_ff + 3'd1;
            if (corner_cnt_ff == CORNER_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last corner lands in memory at this edge, so edge reads
            // that start next cycle see every corner of this run.
            if (wr.last) begin
               edge_cnt_in = '0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rd_issue) begin
               edge_cnt_in = edge_cnt_ff + 4'd1;
            end
            // Once the final edge sits in the output register the next
            // request may start.
            if (out_load && (rd_edge_ff == LAST_EDGE)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (rd_issue) begin
         rd_valid_in = 1'b1;
      end else if (out_load) begin
         rd_valid_in = 1'b0;
      end
      rd_edge_in = rd_issue ? edge_cnt_ff : rd_edge_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         corner_cnt_ff <= '0;
         edge_cnt_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         rd_edge_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         corner_cnt_ff <= corner_cnt_in;
         edge_cnt_ff   <= edge_cnt_in;
         rd_valid_ff   <= rd_valid_in;
         rd_edge_ff    <= rd_edge_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_edge_ff <= rd_edge_ff;
         rsp_sx_ff   <= rd_data_a[S-1:0];
         rsp_sy_ff   <= rd_data_a[2*S-1:S];
         rsp_ex_ff   <= rd_data_b[S-1:0];
         rsp_ey_ff   <= rd_data_b[2*S-1:S];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DW'({rsp_ey_ff, rsp_ex_ff, rsp_sy_ff, rsp_sx_ff, rsp_edge_ff});
   assign rsp_tlast  = (rsp_edge_ff == LAST_EDGE);

endmodule
